/* rtl/core/box_reanchor_clamp_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the rectangle re-anchor block.
// Both macros sample on the rising edge of clock and are off during reset.
// ---------------------------------------------------------------------------
`ifndef BOX_REANCHOR_CLAMP_MACROS_SVH
`define BOX_REANCHOR_CLAMP_MACROS_SVH

// Same-cycle implication.
`define BRC_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("box_reanchor_clamp: same-cycle check failed");

// Next-cycle implication.
`define BRC_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("box_reanchor_clamp: next-cycle check failed");

`endif

/* rtl/core/brc_pkg.sv */
// ---------------------------------------------------------------------------
// brc_pkg
// Shared types for the rectangle re-anchor block.
// ---------------------------------------------------------------------------
`default_nettype none

package brc_pkg;

   // Pipeline control handed to the divider: advance enable and entry valid.
   typedef struct packed {
      logic advance;
      logic valid;
   } pipe_ctl_type;

endpackage

`default_nettype wire

/* rtl/core/brc_divider.sv */
// ---------------------------------------------------------------------------
// brc_divider
// Pipelined restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module brc_divider #(
   parameter int NUM_W = 65,
   parameter int DEN_W = 33
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire brc_pkg::pipe_ctl_type ctl,
   input  wire logic [NUM_W-1:0]      num,
   input  wire logic [DEN_W-1:0]      den,
   output logic [NUM_W-1:0]           quo,
   output logic                       out_valid
);
   import brc_pkg::*;

   logic [DEN_W-1:0] rem_ff  [0:NUM_W];
   logic [DEN_W-1:0] rem_in  [0:NUM_W];
   logic [NUM_W-1:0] work_ff [0:NUM_W];
   logic [NUM_W-1:0] work_in [0:NUM_W];
   logic [DEN_W-1:0] den_ff  [0:NUM_W];
   logic [DEN_W-1:0] den_in  [0:NUM_W];
   logic [NUM_W:0]   vld_ff;
   logic [NUM_W:0]   vld_in;

   // One shift and conditional subtract per stage; quotient bits shift into work.
   always_comb begin
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;
      rem_in[0]  = '0;
      work_in[0] = num;
      den_in[0]  = den;
      for (int k = 0; k < NUM_W; k++) begin
         trial = {rem_ff[k], work_ff[k][NUM_W-1]};
         diff  = trial - {1'b0, den_ff[k]};
         ge    = (trial >= {1'b0, den_ff[k]});
         rem_in[k+1]  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         work_in[k+1] = {work_ff[k][NUM_W-2:0], ge};
         den_in[k+1]  = den_ff[k];
      end
      vld_in = {vld_ff[NUM_W-1:0], ctl.valid};
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (ctl.advance) begin
         vld_ff <= vld_in;
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         for (int k = 0; k <= NUM_W; k++) begin
            rem_ff[k]  <= rem_in[k];
            work_ff[k] <= work_in[k];
            den_ff[k]  <= den_in[k];
         end
      end
   end

   assign quo       = work_ff[NUM_W];
   assign out_valid = vld_ff[NUM_W];

endmodule

`default_nettype wire

/* rtl/core/box_reanchor_clamp.sv */
// ---------------------------------------------------------------------------
// box_reanchor_clamp
// Rescales a rectangle from a source area into a target area with exact
// half-away-from-zero rounding, saturates, then clamps into a non-empty target.
//
//   Channel  Direction  Handshake              Content
//   req_     in         req_valid/req_ready    rectangle, source, target
//   rsp_     out        rsp_valid/rsp_ready    new position and size
//
// The depth is set by the divider,
// which retires one quotient bit per stage. One beat per cycle while rsp_ is not stalled.
// Reset clears every valid bit; payload registers are not reset.
// A stall at rsp_ holds the whole pipeline in place, so nothing is lost.
// ---------------------------------------------------------------------------
`default_nettype none

module box_reanchor_clamp #(
   parameter int COORD_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_rect_x,
   input  wire logic [31:0] req_rect_y,
   input  wire logic [31:0] req_rect_w,
   input  wire logic [31:0] req_rect_h,
   input  wire logic [31:0] req_src_x,
   input  wire logic [31:0] req_src_y,
   input  wire logic [31:0] req_src_w,
   input  wire logic [31:0] req_src_h,
   input  wire logic [31:0] req_dst_x,
   input  wire logic [31:0] req_dst_y,
   input  wire logic [31:0] req_dst_w,
   input  wire logic [31:0] req_dst_h,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [31:0]      rsp_out_w,
   output logic [31:0]      rsp_out_h
);
   import brc_pkg::*;

   localparam int N     = COORD_BITS;
   localparam int NUM_W = 2 * N + 1;
   localparam int DEN_W = N + 1;
   localparam int SW    = 2 * N + 2;

   localparam logic signed [N+1:0] CMAX2 = {3'b000, {(N-1){1'b1}}};
   localparam logic signed [N+1:0] CMIN2 = {3'b111, {(N-1){1'b0}}};
   localparam logic signed [SW-1:0] CMAXW = {{(N+3){1'b0}}, {(N-1){1'b1}}};
   localparam logic signed [SW-1:0] CMINW = {{(N+3){1'b1}}, {(N-1){1'b0}}};

   typedef struct packed {
      logic signed [N-1:0] tx;
      logic signed [N-1:0] ty;
      logic signed [N-1:0] tw;
      logic signed [N-1:0] th;
      logic signed [N-1:0] rw;
      logic signed [N-1:0] rh;
      logic                neg_x;
      logic                neg_y;
   } side_type;

   // Saturate a wide position to the coordinate range.
   function automatic logic signed [N-1:0] sat_wide(input logic signed [SW-1:0] v);
      logic signed [N-1:0] r;
      if (v > CMAXW)      r = CMAXW[N-1:0];
      else if (v < CMINW) r = CMINW[N-1:0];
      else                r = v[N-1:0];
      return r;
   endfunction

   // Push a position inside [start, start+len) for a given clamped size.
   function automatic logic signed [N-1:0] clamp_pos(
      input logic signed [N-1:0] pos,
      input logic signed [N-1:0] size,
      input logic signed [N-1:0] start,
      input logic signed [N-1:0] len
   );
      logic signed [N+1:0] endv;
      logic signed [N+1:0] room;
      logic signed [N-1:0] r;
      endv = (N+2)'(start) + (N+2)'(len);
      room = endv - (N+2)'(size);
      if (pos < start) begin
         r = start;
      end else if ((N+2)'(pos) + (N+2)'(size) > endv) begin
         if (room > CMAX2)      r = CMAX2[N-1:0];
         else if (room < CMIN2) r = CMIN2[N-1:0];
         else                   r = room[N-1:0];
      end else begin
         r = pos;
      end
      return r;
   endfunction

   // Force a size into 1 .. len.
   function automatic logic signed [N-1:0] clamp_size(
      input logic signed [N-1:0] size,
      input logic signed [N-1:0] len
   );
      logic signed [N-1:0] r;
      if (size < N'(1))    r = N'(1);
      else if (size > len) r = len;
      else                 r = size;
      return r;
   endfunction

   logic adv;

   // Stage A: sign extension, offsets, magnitudes and signs.
   logic                 a_v_ff;
   logic [N:0]           a_ux_ff, a_uy_ff;
   logic [N-1:0]         a_utw_ff, a_uth_ff;
   logic signed [N-1:0]  a_sw_ff, a_sh_ff;
   side_type             a_side_ff, a_side_in;
   logic signed [N-1:0]  rx, ry, sx, sy, tw_i, th_i;
   logic signed [N:0]    dx, dy;

   always_comb begin
      rx   = req_rect_x[N-1:0];
      ry   = req_rect_y[N-1:0];
      sx   = req_src_x[N-1:0];
      sy   = req_src_y[N-1:0];
      tw_i = req_dst_w[N-1:0];
      th_i = req_dst_h[N-1:0];
      dx   = (N+1)'(rx) - (N+1)'(sx);
      dy   = (N+1)'(ry) - (N+1)'(sy);
      a_side_in.tx    = req_dst_x[N-1:0];
      a_side_in.ty    = req_dst_y[N-1:0];
      a_side_in.tw    = tw_i;
      a_side_in.th    = th_i;
      a_side_in.rw    = req_rect_w[N-1:0];
      a_side_in.rh    = req_rect_h[N-1:0];
      a_side_in.neg_x = dx[N] ^ tw_i[N-1];
      a_side_in.neg_y = dy[N] ^ th_i[N-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ux_ff   <= dx[N] ? (N+1)'(-dx) : dx;
         a_uy_ff   <= dy[N] ? (N+1)'(-dy) : dy;
         a_utw_ff  <= tw_i[N-1] ? N'(-tw_i) : tw_i;
         a_uth_ff  <= th_i[N-1] ? N'(-th_i) : th_i;
         a_sw_ff   <= req_src_w[N-1:0];
         a_sh_ff   <= req_src_h[N-1:0];
         a_side_ff <= a_side_in;
      end
   end

   // Stage B: magnitude products.
   logic                b_v_ff;
   logic [2*N-1:0]      b_px_ff, b_py_ff;
   logic signed [N-1:0] b_sw_ff, b_sh_ff;
   side_type            b_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         b_px_ff   <= {{(N-1){1'b0}}, a_ux_ff} * {{N{1'b0}}, a_utw_ff};
         b_py_ff   <= {{(N-1){1'b0}}, a_uy_ff} * {{N{1'b0}}, a_uth_ff};
         b_sw_ff   <= a_sw_ff;
         b_sh_ff   <= a_sh_ff;
         b_side_ff <= a_side_ff;
      end
   end

   // Rounded quotient operands: (2*p + s) / (2*s); nonpositive s gives zero.
   logic [NUM_W-1:0] num_x, num_y;
   logic [DEN_W-1:0] den_x, den_y;
   logic             swpos, shpos;

   always_comb begin
      swpos = !b_sw_ff[N-1] && (b_sw_ff != '0);
      shpos = !b_sh_ff[N-1] && (b_sh_ff != '0);
      num_x = swpos ? ({b_px_ff, 1'b0} + NUM_W'(unsigned'(b_sw_ff))) : '0;
      num_y = shpos ? ({b_py_ff, 1'b0} + NUM_W'(unsigned'(b_sh_ff))) : '0;
      den_x = swpos ? {b_sw_ff, 1'b0} : DEN_W'(1);
      den_y = shpos ? {b_sh_ff, 1'b0} : DEN_W'(1);
   end

   pipe_ctl_type    div_ctl;
   logic [NUM_W-1:0] quo_x, quo_y;
   logic            div_vx, div_vy;

   assign div_ctl = '{advance: adv, valid: b_v_ff};

   brc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .num       (num_x),
      .den       (den_x),
      .quo       (quo_x),
      .out_valid (div_vx)
   );

   brc_divider #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
      .clock     (clock),
      .reset     (reset),
      .ctl       (div_ctl),
      .num       (num_y),
      .den       (den_y),
      .quo       (quo_y),
      .out_valid (div_vy)
   );

   // Side data delay line matched to the divider depth.
   side_type   sd_ff [0:NUM_W];
   logic [NUM_W:0] sv_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sd_ff[0] <= b_side_ff;
         for (int k = 1; k <= NUM_W; k++) begin
            sd_ff[k] <= sd_ff[k-1];
         end
      end
   end

   // Stage D: signed offset added to the target edge, saturated.
   logic                d_v_ff;
   logic signed [N-1:0] d_nx_ff, d_ny_ff;
   side_type            d_side_ff;
   logic signed [SW-1:0] off_x, off_y;
   side_type            dl;

   always_comb begin
      dl    = sd_ff[NUM_W];
      off_x = dl.neg_x ? -SW'({1'b0, quo_x}) : SW'({1'b0, quo_x});
      off_y = dl.neg_y ? -SW'({1'b0, quo_y}) : SW'({1'b0, quo_y});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_nx_ff   <= sat_wide(SW'(dl.tx) + off_x);
         d_ny_ff   <= sat_wide(SW'(dl.ty) + off_y);
         d_side_ff <= dl;
      end
   end

   // Stage E: clamp into the target area when it is not empty.
   logic                rsp_valid_ff;
   logic                e_clamp_ff;
   logic signed [N-1:0] e_x_ff, e_y_ff, e_w_ff, e_h_ff;
   logic signed [N-1:0] cw, ch;
   logic                clamp_en;

   always_comb begin
      clamp_en = (d_side_ff.tw >= N'(1)) && (d_side_ff.th >= N'(1));
      cw       = clamp_size(d_side_ff.rw, d_side_ff.tw);
      ch       = clamp_size(d_side_ff.rh, d_side_ff.th);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         e_clamp_ff <= clamp_en;
         if (clamp_en) begin
            e_x_ff <= clamp_pos(d_nx_ff, cw, d_side_ff.tx, d_side_ff.tw);
            e_y_ff <= clamp_pos(d_ny_ff, ch, d_side_ff.ty, d_side_ff.th);
            e_w_ff <= cw;
            e_h_ff <= ch;
         end else begin
            e_x_ff <= d_nx_ff;
            e_y_ff <= d_ny_ff;
            e_w_ff <= d_side_ff.rw;
            e_h_ff <= d_side_ff.rh;
         end
      end
   end

   // Valid bits of the stages outside the divider.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         sv_ff        <= '0;
         d_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff       <= req_valid;
         b_v_ff       <= a_v_ff;
         sv_ff        <= {sv_ff[NUM_W-1:0], b_v_ff};
         d_v_ff       <= div_vx;
         rsp_valid_ff <= d_v_ff;
      end
   end

   // The whole pipeline moves unless a finished beat is held at the output.
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = 32'(e_x_ff);
   assign rsp_out_y = 32'(e_y_ff);
   assign rsp_out_w = 32'(e_w_ff);
   assign rsp_out_h = 32'(e_h_ff);

`include "box_reanchor_clamp_macros.svh"

   // Both dividers and the side delay line stay in step.
   `BRC_ASSERT_IMP(a_div_align, 1'b1, (div_vx == sv_ff[NUM_W]) && (div_vy == div_vx))
   // An accepted beat shows up in the first stage.
   `BRC_ASSERT_NXT(a_entry, req_valid && req_ready, a_v_ff)
   // A clamped result never has a size below one.
   `BRC_ASSERT_IMP(a_size_min, rsp_valid_ff && e_clamp_ff, (e_w_ff >= N'(1)) && (e_h_ff >= N'(1)))

endmodule

`default_nettype wire

/* tb/tb_box_reanchor_clamp.sv */
// ---------------------------------------------------------------------------
// tb_box_reanchor_clamp
// Self-checking testbench for the rectangle re-anchor and clamp block.
// Each request beat is predicted in the testbench: the offset is rescaled
// with exact rounding, saturated and clamped into a non-empty target area. Response
// beats are compared in order against the predicted results. Directed
// corner cases run first, then random traffic under several idle patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_box_reanchor_clamp;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;
   localparam int     CYCLE_LIMIT = 400000;
   localparam int     DRAIN_CYCLES = 90;

   typedef struct packed {
      logic [31:0] rect_x, rect_y, rect_w, rect_h;
      logic [31:0] src_x, src_y, src_w, src_h;
      logic [31:0] dst_x, dst_y, dst_w, dst_h;
   } box_req_type;

   typedef struct packed {
      logic [31:0] out_x, out_y, out_w, out_h;
   } box_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   box_req_type req_box = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   box_rsp_type rsp_box;

   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   int          error_count = 0;
   int          cycle_count = 0;
   box_rsp_type pending_boxes[$];

   box_reanchor_clamp dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_rect_x (req_box.rect_x),
      .req_rect_y (req_box.rect_y),
      .req_rect_w (req_box.rect_w),
      .req_rect_h (req_box.rect_h),
      .req_src_x  (req_box.src_x),
      .req_src_y  (req_box.src_y),
      .req_src_w  (req_box.src_w),
      .req_src_h  (req_box.src_h),
      .req_dst_x  (req_box.dst_x),
      .req_dst_y  (req_box.dst_y),
      .req_dst_w  (req_box.dst_w),
      .req_dst_h  (req_box.dst_h),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_out_x  (rsp_box.out_x),
      .rsp_out_y  (rsp_box.out_y),
      .rsp_out_w  (rsp_box.out_w),
      .rsp_out_h  (rsp_box.out_h)
   );

   // Free-running clock, 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Saturate to the signed 32-bit coordinate range.
   function automatic longint sat_coord(input longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // Offset times target size over source size, rounded half away from zero.
   function automatic longint rescale_offset(input longint dx, input longint tw,
                                             input longint sw);
      longint unsigned ux, ut, prod, q;
      logic            neg;
      if (sw <= 0) return 0;
      neg  = (dx < 0) != (tw < 0);
      ux   = (dx < 0) ? -dx : dx;
      ut   = (tw < 0) ? -tw : tw;
      prod = ux * ut;
      q    = (2 * prod + sw) / (2 * sw);
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // Force size into 1..len and push the position inside the area.
   function automatic void clamp_axis(inout longint pos, inout longint size,
                                      input longint start, input longint len);
      longint stop;
      stop = start + len;
      if (size < 1) size = 1;
      else if (size > len) size = len;
      if (pos < start) pos = start;
      else if (pos + size > stop) pos = sat_coord(stop - size);
   endfunction

   // Expected response for one request beat.
   function automatic box_rsp_type reanchor_box(input box_req_type b);
      longint      nx, ny, rw, rh, tx, ty, tw, th;
      box_rsp_type r;
      tx = longint'(signed'(b.dst_x));
      ty = longint'(signed'(b.dst_y));
      tw = longint'(signed'(b.dst_w));
      th = longint'(signed'(b.dst_h));
      rw = longint'(signed'(b.rect_w));
      rh = longint'(signed'(b.rect_h));
      nx = sat_coord(tx + rescale_offset(longint'(signed'(b.rect_x))
                     - longint'(signed'(b.src_x)), tw, longint'(signed'(b.src_w))));
      ny = sat_coord(ty + rescale_offset(longint'(signed'(b.rect_y))
                     - longint'(signed'(b.src_y)), th, longint'(signed'(b.src_h))));
      if (tw >= 1 && th >= 1) begin
         clamp_axis(nx, rw, tx, tw);
         clamp_axis(ny, rh, ty, th);
      end
      r.out_x = nx[31:0];
      r.out_y = ny[31:0];
      r.out_w = rw[31:0];
      r.out_h = rh[31:0];
      return r;
   endfunction

   // Send one request beat, idling first at the current sender rate.
   task automatic send_box(input box_req_type b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_box   <= b;
      do @(posedge clock); while (!req_ready);
      pending_boxes.push_back(reanchor_box(b));
   endtask

   // Hold the sender until every predicted response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_boxes.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [31:0] exp_v,
                                       input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s mismatch: expected %0d actual %0d", name, signed'(exp_v),
                signed'(act_v));
         error_count++;
      end
   endfunction

   // Response checker: each beat against the oldest prediction.
   always @(posedge clock) begin
      box_rsp_type exp_box;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_boxes.size() == 0) begin
            $error("response beat with no prediction pending");
            error_count++;
         end else begin
            exp_box = pending_boxes.pop_front();
            check_field("out_x", exp_box.out_x, rsp_box.out_x);
            check_field("out_y", exp_box.out_y, rsp_box.out_y);
            check_field("out_w", exp_box.out_w, rsp_box.out_w);
            check_field("out_h", exp_box.out_h, rsp_box.out_h);
         end
      end
   end

   // Receiver backpressure at the current stall rate.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic box_req_type make_box(
      input int rx, input int ry, input int rw, input int rh,
      input int sx, input int sy, input int sw, input int sh,
      input int tx, input int ty, input int tw, input int th);
      box_req_type b;
      b = '{rx, ry, rw, rh, sx, sy, sw, sh, tx, ty, tw, th};
      return b;
   endfunction

   // Random coordinate: full range, small, or near an extreme.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(5))
         0, 1:    return $urandom;
         2:       return 32'h8000_0000 + $urandom_range(3);
         3:       return 32'h7FFF_FFFF - $urandom_range(3);
         default: return $urandom_range(4000) - 2000;
      endcase
   endfunction

   // Random size: mostly positive and modest, sometimes anything.
   function automatic logic [31:0] rand_size();
      case ($urandom_range(7))
         0:       return $urandom;
         1:       return $urandom_range(2) - 2;
         2:       return 32'h7FFF_FFFF - $urandom_range(3);
         default: return $urandom_range(3000) + 1;
      endcase
   endfunction

   task automatic test_corner_cases();
      int lo, hi;
      lo = 32'h8000_0000;
      hi = 32'h7FFF_FFFF;
      // Field extremes.
      send_box(make_box(lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo, lo));
      send_box(make_box(hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi, hi));
      send_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_box(make_box(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
      // Largest offset times most negative target size, then saturation.
      send_box(make_box(hi, hi, 10, 10, lo, lo, 1, 1, 0, 0, lo, lo));
      send_box(make_box(hi, lo, 5, 5, lo, hi, 1, 1, hi, lo, hi, hi));
      send_box(make_box(hi, hi, 5, 5, lo, lo, 1, 1, hi, hi, -5, -5));
      // Source size not positive leaves a zero offset.
      send_box(make_box(500, 700, 20, 20, 0, 0, 0, -3, 100, 100, 1000, 1000));
      send_box(make_box(500, 700, 20, 20, 0, 0, lo, 0, 100, 100, 1000, 1000));
      // Halfway rounding goes away from zero on both sides.
      send_box(make_box(1, -1, 1, 1, 0, 0, 2, 2, 0, 0, 1, 1));
      send_box(make_box(-1, 3, 1, 1, 0, 0, 2, 2, -100, -100, 1, 1));
      send_box(make_box(3, -3, 1, 1, 0, 0, 2, 2, -100, -100, -1, 1));
      // Empty target skips clamping, also with a negative target size.
      send_box(make_box(10, 10, -7, 0, 0, 0, 100, 100, 50, 50, 0, 200));
      send_box(make_box(10, 10, 9, -4, 0, 0, 100, 100, 50, 50, 200, -2));
      // Size clamped to at least one and to the target size.
      send_box(make_box(10, 10, 0, lo, 0, 0, 100, 100, 0, 0, 100, 100));
      send_box(make_box(10, 10, 500, hi, 0, 0, 100, 100, 0, 0, 100, 100));
      // Position below the target start, and edge past the target end.
      send_box(make_box(-50, -50, 10, 10, 0, 0, 100, 100, 0, 0, 100, 100));
      send_box(make_box(95, 99, 10, 10, 0, 0, 100, 100, 0, 0, 100, 100));
      // Large targets at both ends of the coordinate range.
      send_box(make_box(hi, hi, 1, 1, 0, 0, 1, 1, hi - 1, hi - 1, hi, hi));
      send_box(make_box(0, 0, 3, 3, 0, 0, 1, 1, lo, lo, hi, hi));
      wait_drained();
   endtask

   task automatic test_random_boxes(input int count, input int tx_pct, input int rx_pct);
      box_req_type b;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      repeat (count) begin
         b.rect_x = rand_coord();
         b.rect_y = rand_coord();
         b.rect_w = rand_size();
         b.rect_h = rand_size();
         b.src_x  = rand_coord();
         b.src_y  = rand_coord();
         b.src_w  = rand_size();
         b.src_h  = rand_size();
         b.dst_x  = rand_coord();
         b.dst_y  = rand_coord();
         b.dst_w  = rand_size();
         b.dst_h  = rand_size();
         send_box(b);
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_random_boxes(200, 23, 72);
      test_random_boxes(200, 72, 23);
      test_random_boxes(200, 0, 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_boxes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
